[design/htfd_pkg.sv]
package htfd_pkg;

  // CRC-8 settings of the sensor frame.
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Byte positions within the six-byte frame.
  localparam logic [2:0] PosTempMsb = 3'd0;
  localparam logic [2:0] PosTempLsb = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumMsb  = 3'd3;
  localparam logic [2:0] PosHumLsb  = 3'd4;
  localparam logic [2:0] PosHumCrc  = 3'd5;

  // Result field widths.
  localparam int unsigned TempWidth   = 15;
  localparam int unsigned HumWidth    = 14;
  localparam int unsigned StatusWidth = 2;

  // Scaling constants, all in hundredths.
  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [13:0] HumScale   = 14'd12500;
  localparam logic [13:0] HumOffset  = 14'd600;
  localparam logic [13:0] HumMax     = 14'd10000;
  localparam logic [13:0] HumUpper   = 14'd10600;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk      = 2'd0,
    StatusTempCrc = 2'd1,
    StatusHumCrc  = 2'd2
  } status_e;

  // One complete frame, handed from the frame tracker to the scaler.
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    status_e     status;
  } frame_rec_t;

  // One byte step of the CRC, MSB first, unrolled over eight bits.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[design/htfd_if.sv]
// Byte channel into the decoder.
interface htfd_in_if import htfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// Result channel out of the decoder.
interface htfd_out_if import htfd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [TempWidth-1:0]   temperature_centi;
  logic [HumWidth-1:0]           humidity_centi;
  logic [StatusWidth-1:0]        status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output status, input ready);
  modport sink (input valid, input temperature_centi, input humidity_centi,
                input status, output ready);
endinterface

[design/htfd_frame.sv]
module htfd_frame import htfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  htfd_in_if.sink     in_i,
  output logic        rec_valid_o,
  input  logic        rec_ready_i,
  output frame_rec_t  rec_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_word_q, temp_word_d;
  logic [15:0] hum_word_q, hum_word_d;
  logic        temp_bad_q, temp_bad_d;
  logic        rec_valid_q, rec_valid_d;
  frame_rec_t  rec_q;
  logic        in_ready;
  logic        accept;
  logic        last_byte;
  status_e     status;

  // A byte may enter whenever the frame record slot is free or drains this cycle.
  assign in_ready   = !rec_valid_q || rec_ready_i;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // A start mark or an unused position restarts the frame at byte zero.
  assign pos_eff   = (in_i.frame_start || pos_q > PosHumCrc) ? PosTempMsb : pos_q;
  assign last_byte = (pos_eff == PosHumCrc);

  // Per-position update of the frame state.
  always_comb begin
    crc_d       = crc_q;
    temp_word_d = temp_word_q;
    hum_word_d  = hum_word_q;
    temp_bad_d  = temp_bad_q;
    pos_d       = pos_eff + 3'd1;
    unique case (pos_eff)
      PosTempMsb: begin
        crc_d       = crc8_byte(CrcInit, in_i.data_byte);
        temp_word_d = {in_i.data_byte, 8'h00};
      end
      PosTempLsb: begin
        crc_d       = crc8_byte(crc_q, in_i.data_byte);
        temp_word_d = {temp_word_q[15:8], in_i.data_byte};
      end
      PosTempCrc: begin
        temp_bad_d = (crc_q != in_i.data_byte);
        crc_d      = CrcInit;
      end
      PosHumMsb: begin
        crc_d      = crc8_byte(CrcInit, in_i.data_byte);
        hum_word_d = {in_i.data_byte, 8'h00};
      end
      PosHumLsb: begin
        crc_d      = crc8_byte(crc_q, in_i.data_byte);
        hum_word_d = {hum_word_q[15:8], in_i.data_byte};
      end
      default: begin
        crc_d = CrcInit;
        pos_d = PosTempMsb;
      end
    endcase
  end

  // Status of a finished frame; the temperature check wins.
  always_comb begin
    if (temp_bad_q) begin
      status = StatusTempCrc;
    end else if (crc_q != in_i.data_byte) begin
      status = StatusHumCrc;
    end else begin
      status = StatusOk;
    end
  end

  // The record slot fills on the sixth byte and empties on a transfer.
  always_comb begin
    if (accept && last_byte) begin
      rec_valid_d = 1'b1;
    end else if (rec_ready_i) begin
      rec_valid_d = 1'b0;
    end else begin
      rec_valid_d = rec_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosTempMsb;
      crc_q       <= CrcInit;
      temp_word_q <= '0;
      hum_word_q  <= '0;
      temp_bad_q  <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      rec_valid_q <= rec_valid_d;
      if (accept) begin
        pos_q       <= pos_d;
        crc_q       <= crc_d;
        temp_word_q <= temp_word_d;
        hum_word_q  <= hum_word_d;
        temp_bad_q  <= temp_bad_d;
      end
    end
  end

  // Frame record payload.
  always_ff @(posedge clk_i) begin
    if (accept && last_byte) begin
      rec_q.temp_word <= temp_word_q;
      rec_q.hum_word  <= hum_word_q;
      rec_q.status    <= status;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

[design/htfd_scale.sv]
module htfd_scale import htfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rec_valid_i,
  output logic        rec_ready_o,
  input  frame_rec_t  rec_i,
  htfd_out_if.source  out_o
);

  logic [30:0]           t_prod;
  logic [31:0]           t_sum;
  logic [14:0]           t_quo;
  logic [29:0]           h_prod;
  logic [30:0]           h_sum;
  logic [13:0]           h_quo;
  logic [TempWidth-1:0]  temp_d, temp_q;
  logic [HumWidth-1:0]   hum_d, hum_q;
  logic [HumWidth-1:0]   hum_clamped;
  status_e               status_q;
  logic                  out_valid_q, out_valid_d;
  logic                  load;

  assign rec_ready_o = !out_valid_q || out_o.ready;
  assign load        = rec_valid_i && rec_ready_o;

  // Scale by a constant, then divide by 65535 as (x + (x >> 16) + 1) >> 16,
  // which is exact for quotients well below 65536.
  assign t_prod = 31'(rec_i.temp_word) * 31'(TempScale);
  assign t_sum  = 32'(t_prod) + 32'(t_prod[30:16]) + 32'd1;
  assign t_quo  = t_sum[30:16];

  assign h_prod = 30'(rec_i.hum_word) * 30'(HumScale);
  assign h_sum  = 31'(h_prod) + 31'(h_prod[29:16]) + 31'd1;
  assign h_quo  = h_sum[29:16];

  // Offset and clamp the humidity to its valid range.
  always_comb begin
    if (h_quo < HumOffset) begin
      hum_clamped = '0;
    end else if (h_quo > HumUpper) begin
      hum_clamped = HumMax;
    end else begin
      hum_clamped = h_quo - HumOffset;
    end
  end

  // Values are zeroed when either CRC failed.
  always_comb begin
    if (rec_i.status == StatusOk) begin
      temp_d = t_quo - TempOffset;
      hum_d  = hum_clamped;
    end else begin
      temp_d = '0;
      hum_d  = '0;
    end
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      status_q <= rec_i.status;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.temperature_centi = $signed(temp_q);
  assign out_o.humidity_centi    = hum_q;
  assign out_o.status            = status_q;

endmodule

[design/humidity_temp_frame_decoder_unit.sv]
// A sixth frame byte's result passes the frame record and result registers.
// Throughput: one byte per cycle when not stalled; the CRC byte step and the
// constant scaling each fit a single pipeline stage between registers.
// Reset: rst_ni is asynchronous and active low; it returns the frame to byte
// zero, sets the running CRC to 0xFF and empties both pipeline stages.
module humidity_temp_frame_decoder_unit import htfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  htfd_in_if.sink     in_i,
  htfd_out_if.source  out_o
);

  logic       rec_valid;
  logic       rec_ready;
  frame_rec_t rec;

  // Frame tracking and CRC checks.
  htfd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  // Conversion to hundredths and result register.
  htfd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_ready_o (rec_ready),
    .rec_i       (rec),
    .out_o       (out_o)
  );

endmodule
